// File: rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width and reset value of the window length register
    localparam int              WLEN_BITS = 7;
    localparam logic [6:0]      WLEN_RST  = 7'd3;

    // Per-cycle control broadcast to every cell of the sorted row
    typedef struct packed {
        logic load;   // an item is accepted this cycle
        logic full;   // window is full, so the oldest entry leaves
    } step_t;

endpackage

// File: rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// A result item leaves from the output register, loaded after the cell row updates.
// Throughput: one item per cycle while results are taken; the row updates per item.
// The cell row inserts and removes together; one output register follows.
// Reset: window emptied, window length 3; the cells themselves are not cleared.
// A window length write or a restart item empties the window as well.
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the newest window_len samples, given as twice the median.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [swm_pkg::WLEN_BITS-1:0] cfg_wr_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_restart,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_median_x2
);
    import swm_pkg::*;

    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // clamp the written length to 1..MAX_WINDOW
    function automatic logic [CNT_W-1:0] eff_len(input logic [WLEN_BITS-1:0] wl);
        logic [CNT_W-1:0] r;
        if (wl == '0) begin
            r = CNT_W'(1);
        end else if (32'(wl) > 32'(MAX_WINDOW)) begin
            r = CNT_W'(MAX_WINDOW);
        end else begin
            r = CNT_W'(wl);
        end
        return r;
    endfunction

    logic [CNT_W-1:0] win_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg;
    logic             pend_res_reg, pend_res_next;

    logic             accept;
    logic             move;
    logic             out_free;
    logic [CNT_W-1:0] n_eff;
    step_t            step;
    logic [AGE_W-1:0] last_age;
    logic [AGE_W-1:0] lo_idx, hi_idx;
    logic [CNT_W-1:0] half;

    logic [MAX_WINDOW-1:0] cell_valid;
    logic [MAX_WINDOW-1:0] rm_vec;
    logic [MAX_WINDOW-1:0] above_rm;
    logic [MAX_WINDOW-1:0] shift_vec;
    logic [MAX_WINDOW-1:0] le_vec;
    logic [MAX_WINDOW-1:0] le_u_vec;

    logic signed [SAMPLE_BITS-1:0] val_arr   [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] u_val_arr [MAX_WINDOW];
    logic [AGE_W-1:0]              age_arr   [MAX_WINDOW];
    logic [AGE_W-1:0]              u_age_arr [MAX_WINDOW];

    // handshake: the pending item must leave the cell row before the next one
    assign move    = pend_reg && (!pend_res_reg || out_free);
    assign s_ready = !pend_reg || move;
    assign accept  = s_valid && s_ready;

    // window occupancy seen by this item
    assign n_eff     = s_restart ? '0 : fill_reg;
    assign step.load = accept;
    assign step.full = (n_eff == win_reg);
    assign last_age  = AGE_W'(win_reg - CNT_W'(1));
    assign fill_next = step.full ? n_eff : CNT_W'(n_eff + CNT_W'(1));
    assign pend_res_next = (fill_next == win_reg);

    // middle positions of the sorted row
    assign half   = win_reg >> 1;
    assign hi_idx = AGE_W'(half);
    assign lo_idx = win_reg[0] ? AGE_W'(half) : AGE_W'(half - CNT_W'(1));

    // cells at or above the leaving entry shift down
    assign above_rm  = ~((rm_vec << 1) - MAX_WINDOW'(1));
    assign shift_vec = above_rm | rm_vec;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= eff_len(WLEN_RST);
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            pend_res_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_reg  <= eff_len(cfg_wr_data);
                fill_reg <= '0;
            end else if (accept) begin
                fill_reg <= fill_next;
            end
            if (accept) begin
                pend_reg     <= 1'b1;
                pend_res_reg <= pend_res_next;
            end else if (move) begin
                pend_reg     <= 1'b0;
                pend_res_reg <= 1'b0;
            end
        end
    end

    // row of sorting cells
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic                          nxt_le;
        logic signed [SAMPLE_BITS-1:0] nxt_value;
        logic [AGE_W-1:0]              nxt_age;
        logic                          prv_le_u;
        logic signed [SAMPLE_BITS-1:0] prv_u_value;
        logic [AGE_W-1:0]              prv_u_age;

        assign cell_valid[i] = (CNT_W'(i) < n_eff);

        if (i + 1 < MAX_WINDOW) begin : g_nxt
            assign nxt_le    = le_vec[i+1];
            assign nxt_value = val_arr[i+1];
            assign nxt_age   = age_arr[i+1];
        end else begin : g_top
            assign nxt_le    = 1'b0;
            assign nxt_value = '0;
            assign nxt_age   = '0;
        end

        if (i > 0) begin : g_prv
            assign prv_le_u    = le_u_vec[i-1];
            assign prv_u_value = u_val_arr[i-1];
            assign prv_u_age   = u_age_arr[i-1];
        end else begin : g_bot
            assign prv_le_u    = 1'b1;
            assign prv_u_value = '0;
            assign prv_u_age   = '0;
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .aclk        (aclk),
            .step        (step),
            .sample      (s_sample),
            .valid_in    (cell_valid[i]),
            .last_age    (last_age),
            .shift_in    (shift_vec[i]),
            .le_o        (le_vec[i]),
            .rm_o        (rm_vec[i]),
            .value_o     (val_arr[i]),
            .age_o       (age_arr[i]),
            .nxt_le      (nxt_le),
            .nxt_value   (nxt_value),
            .nxt_age     (nxt_age),
            .le_u_o      (le_u_vec[i]),
            .u_value_o   (u_val_arr[i]),
            .u_age_o     (u_age_arr[i]),
            .prv_le_u    (prv_le_u),
            .prv_u_value (prv_u_value),
            .prv_u_age   (prv_u_age)
        );
    end

    // median select, add and output register
    swm_out #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (move && pend_res_reg),
        .free_o      (out_free),
        .lo_idx      (lo_idx),
        .hi_idx      (hi_idx),
        .cell_val    (val_arr),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_median_x2 (m_median_x2)
    );

endmodule

// File: rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: holds a sample and its age, and on each
// item takes its new content from itself, a neighbor or the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 6
) (
    input  logic                          aclk,
    input  swm_pkg::step_t                step,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          valid_in,
    input  logic [AGE_W-1:0]              last_age,
    input  logic                          shift_in,
    // own status
    output logic                          le_o,
    output logic                          rm_o,
    output logic signed [SAMPLE_BITS-1:0] value_o,
    output logic [AGE_W-1:0]              age_o,
    // from the next cell (one position higher)
    input  logic                          nxt_le,
    input  logic signed [SAMPLE_BITS-1:0] nxt_value,
    input  logic [AGE_W-1:0]              nxt_age,
    // compacted entry handed on to the next cell
    output logic                          le_u_o,
    output logic signed [SAMPLE_BITS-1:0] u_value_o,
    output logic [AGE_W-1:0]              u_age_o,
    // compacted entry of the previous cell
    input  logic                          prv_le_u,
    input  logic signed [SAMPLE_BITS-1:0] prv_u_value,
    input  logic [AGE_W-1:0]              prv_u_age
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic [AGE_W-1:0]              age_reg, age_next;

    // local compares
    assign le_o    = valid_in && !(value_reg > sample);
    assign rm_o    = step.full && valid_in && (age_reg == last_age);
    assign value_o = value_reg;
    assign age_o   = age_reg;

    // list with the oldest entry taken out: cells at or above it pull down
    assign u_value_o = shift_in ? nxt_value : value_reg;
    assign u_age_o   = shift_in ? nxt_age   : age_reg;
    assign le_u_o    = shift_in ? nxt_le    : le_o;

    // insertion of the new sample into the compacted list
    always_comb begin
        if (le_u_o) begin
            value_next = u_value_o;
            age_next   = AGE_W'(u_age_o + 1'b1);
        end else if (prv_le_u) begin
            value_next = sample;
            age_next   = '0;
        end else begin
            value_next = prv_u_value;
            age_next   = AGE_W'(prv_u_age + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (step.load) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// File: rtl/swm_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_out
// Output stage: picks the two middle cells, adds them and holds the result
// item until it is taken.
// ----------------------------------------------------------------------------
module swm_out #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    output logic                          free_o,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] lo_idx,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] hi_idx,
    input  logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW],
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [SAMPLE_BITS:0]   m_median_x2
);
    import swm_pkg::*;

    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic                          valid_reg;
    logic signed [SAMPLE_BITS:0]   median_reg, median_next;
    logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;

    assign free_o = !valid_reg || m_ready;

    // middle taps
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (AGE_W'(i) == lo_idx) lo_val = cell_val[i];
            if (AGE_W'(i) == hi_idx) hi_val = cell_val[i];
        end
    end

    assign median_next = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            median_reg <= median_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_median_x2 = median_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sliding_window_median. A driver and a monitor run
// as clocked blocks. The monitor keeps a copy of the window in arrival order
// and in sorted order, and computes twice the median for every sample taken
// on a full window, and checks the result items in order. Window lengths are
// swept from 0 to 127 by phase; both sides idle at random in phases 0 to 5.
// ----------------------------------------------------------------------------
module tb;

    import swm_pkg::*;

    localparam int SW        = 16;
    localparam int MAXW      = 64;
    localparam int CYC_LIMIT = 200000;
    localparam int N_PHASES  = 10;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 restart;
    } sample_item_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [WLEN_BITS-1:0]   cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic signed [SW-1:0]   s_sample;
    logic                   s_restart;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [SW:0]     m_median_x2;

    // stimulus and scoreboard state
    sample_item_t           in_q[$];
    sample_item_t           drv_item;
    logic signed [SW:0]     median_exp_q[$];
    logic signed [SW:0]     pred_x2;
    logic signed [SW:0]     exp_x2;
    logic                   in_taken;
    int                     n_queued;
    int                     n_accepted;
    int                     n_err;
    int                     src_idle_pct;
    int                     sink_idle_pct;
    int                     cyc_count;

    // window copy kept by the predictor
    int                     win_ring[MAXW];
    int                     win_sorted[MAXW];
    int                     win_oldest;
    int                     win_fill;
    logic [WLEN_BITS-1:0]   win_len_reg;

    sliding_window_median #(
        .MAX_WINDOW  (MAXW),
        .SAMPLE_BITS (SW)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_median_x2 (m_median_x2)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Insert v into the sorted list that holds count entries
    function automatic void sorted_put(input int count, input int v);
        int i;
        i = count;
        while (i > 0 && win_sorted[i-1] > v) begin
            win_sorted[i] = win_sorted[i-1];
            i--;
        end
        win_sorted[i] = v;
    endfunction

    // Take one sample into the window copy; returns 1 when a median is due
    function automatic bit next_median_x2(input logic signed [SW-1:0] smp,
                                          input logic rst,
                                          output logic signed [SW:0] med2);
        int eff;
        int slot;
        int i;
        int v;
        int m;
        eff = (win_len_reg == 0) ? 1 : (win_len_reg > MAXW) ? MAXW : int'(win_len_reg);
        v = int'(smp);
        med2 = '0;
        if (rst || win_fill > eff) begin
            win_fill = 0;
            win_oldest = 0;
        end
        if (win_fill < eff) begin
            win_ring[win_fill] = v;
            sorted_put(win_fill, v);
            win_fill++;
            win_oldest = 0;
        end else begin
            // the oldest sample leaves by value, then the new one goes in
            slot = win_oldest % eff;
            i = 0;
            while (i < eff && win_sorted[i] != win_ring[slot]) i++;
            if (i < eff) begin
                while (i + 1 < eff) begin
                    win_sorted[i] = win_sorted[i+1];
                    i++;
                end
            end
            sorted_put(eff - 1, v);
            win_ring[slot] = v;
            win_oldest = (slot + 1) % eff;
        end
        if (win_fill < eff) return 1'b0;
        if (eff % 2 == 1) m = 2 * win_sorted[eff/2];
        else m = win_sorted[eff/2-1] + win_sorted[eff/2];
        med2 = m[SW:0];
        return 1'b1;
    endfunction

    // Driver: presents queued samples, idles and stalls at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_sample  <= '0;
            s_restart <= 1'b0;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
            if (!s_valid || in_taken) begin
                if (in_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    drv_item   = in_q.pop_front();
                    s_valid   <= 1'b1;
                    s_sample  <= drv_item.sample;
                    s_restart <= drv_item.restart;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: window length writes, result check, then prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg = WLEN_RST;
            win_fill    = 0;
            win_oldest  = 0;
            median_exp_q.delete();
            in_taken   <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (cfg_wr_en) begin
                win_len_reg = cfg_wr_data;
                win_fill    = 0;
                win_oldest  = 0;
            end
            if (m_valid && m_ready) begin
                if (median_exp_q.size() == 0) begin
                    $display("%0t: median_x2 expected none actual %0d", $time, m_median_x2);
                    n_err++;
                end else begin
                    exp_x2 = median_exp_q.pop_front();
                    if (m_median_x2 !== exp_x2) begin
                        $display("%0t: median_x2 expected %0d actual %0d",
                                 $time, exp_x2, m_median_x2);
                        n_err++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (next_median_x2(s_sample, s_restart, pred_x2))
                    median_exp_q = {median_exp_q, pred_x2};
                n_accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == CYC_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_item(input logic signed [SW-1:0] smp, input logic rst);
        sample_item_t it;
        it.sample  = smp;
        it.restart = rst;
        in_q = {in_q, it};
        n_queued++;
    endtask

    // Wait for every item taken and every result seen, then for the pipeline
    task automatic wait_drained();
        while (n_accepted != n_queued || median_exp_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_window_len(input logic [WLEN_BITS-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Mix of near-equal values, rail values and full-range values
    function automatic logic signed [SW-1:0] rand_sample();
        int r;
        r = $urandom_range(7);
        if (r < 2) return SW'($signed($urandom_range(8)) - 4);
        if (r == 2) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        return SW'($urandom);
    endfunction

    // Stimulus
    initial begin : stim
        logic [WLEN_BITS-1:0] wl_tab[N_PHASES];
        int                   n_tab[N_PHASES];
        int                   p;
        int                   k;
        int                   eff;
        logic [WLEN_BITS-1:0] wl;

        wl_tab = '{7'd1, 7'd64, 7'd0, 7'd2, 7'd127, 7'd4, 7'd33, 7'd5, 7'd6, 7'd3};
        n_tab  = '{80, 180, 50, 90, 170, 100, 160, 110, 100, 110};

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_sample      = '0;
        s_restart     = 1'b0;
        m_ready       = 1'b0;
        in_taken      = 1'b0;
        n_queued      = 0;
        n_accepted    = 0;
        n_err         = 0;
        cyc_count     = 0;
        src_idle_pct  = 33;
        sink_idle_pct = 66;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items on the reset window length of three
        queue_item(16'sh7fff, 1'b0);
        queue_item(16'sh7fff, 1'b0);
        queue_item(16'sh7fff, 1'b0);    // top rail
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh8000, 1'b0);    // bottom rail
        queue_item(16'sd0, 1'b0);
        queue_item(-16'sd1, 1'b0);
        queue_item(16'sd1, 1'b0);
        queue_item(16'sd5, 1'b0);
        queue_item(16'sd5, 1'b0);
        queue_item(16'sd5, 1'b0);       // equal values leave by value
        queue_item(-16'sd7, 1'b1);      // restart on a full window
        queue_item(16'sd9, 1'b0);
        queue_item(-16'sd7, 1'b1);      // restart while filling
        queue_item(16'sd2, 1'b0);
        queue_item(16'sd3, 1'b0);
        queue_item(16'sh5555, 1'b0);
        queue_item(16'shaaaa, 1'b0);
        queue_item(16'sd100, 1'b0);
        queue_item(-16'sd100, 1'b0);
        wait_drained();

        // random phases over a sweep of window lengths
        for (p = 0; p < N_PHASES; p++) begin
            wl = wl_tab[p];
            if (p == 6) wl = 7'($urandom_range(64, 1));
            write_window_len(wl);
            eff = (wl == 0) ? 1 : (wl > MAXW) ? MAXW : int'(wl);
            if (p < 3) begin
                src_idle_pct  = 33;
                sink_idle_pct = 66;
            end else if (p < 6) begin
                src_idle_pct  = 66;
                sink_idle_pct = 33;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // restarts kept rare enough that long windows still fill
            for (k = 0; k < n_tab[p]; k++)
                queue_item(rand_sample(), $urandom_range(4 * eff + 20) == 0);
            wait_drained();
        end

        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sliding_window_median.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_out.sv
rtl/sliding_window_median.sv
verif/tb.sv
